// ===== src/label_grouped_column_sum_assert.svh =====
// Assertion macros used by the RTL of the grouped column sum block.
`ifndef LABEL_GROUPED_COLUMN_SUM_ASSERT_SVH
`define LABEL_GROUPED_COLUMN_SUM_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define LGCS_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// When the antecedent holds, the consequent holds at the same edge.
`define LGCS_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// When the antecedent holds, the consequent holds at the next edge.
`define LGCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lgcs_pkg.sv =====
`timescale 1ns / 1ps

package lgcs_pkg;

   localparam int DEF_MAX_LABELS  = 16;
   localparam int DEF_MAX_COLUMNS = 16;

   localparam int LABEL_W     = 4;
   localparam int COLUMN_W    = 4;
   localparam int VALUE_W     = 32;
   localparam int SUM_W       = 48;
   localparam int STATUS_W    = 2;
   localparam int CSR_W       = 5;
   localparam int CSR_INDEX_W = 1;

   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [VALUE_W-1:0] value_type;

   localparam logic CMD_ADD  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_BAD_LABEL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_COLUMN = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_LABELS  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_COLUMNS = 1'b1;

   localparam logic [CSR_W-1:0] NUM_LABELS_RESET  = 5'd16;
   localparam logic [CSR_W-1:0] NUM_COLUMNS_RESET = 5'd16;

   localparam sum_type SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam sum_type SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   function automatic sum_type sat_add(input sum_type a, input value_type v);
      logic signed [SUM_W:0] t;
      t = {a[SUM_W-1], a} + (SUM_W+1)'(v);
      if (t[SUM_W] != t[SUM_W-1]) begin
         return t[SUM_W] ? SUM_MIN : SUM_MAX;
      end
      return t[SUM_W-1:0];
   endfunction

endpackage

// ===== src/lgcs_ram.sv =====
`timescale 1ns / 1ps

module lgcs_ram #(
   parameter int WIDTH  = 48,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/label_grouped_column_sum.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// req       in         req_valid/stall    req_cmd, req_label, req_column, req_value
// rsp       out        rsp_valid/stall    rsp_status, rsp_sum
// csr       in         csr_write          csr_index, csr_data
//
// One item per cycle is sustained unless a result stall or the RAM clear holds it;
// each item goes through the s1 stage and the result register. The rate is set by the
// one read-modify-write of the sum RAM, with a bypass for back-to-back same-cell items.
// After reset the RAM is cleared, one cell per cycle, across all MAX_LABELS * MAX_COLUMNS
// cells, during which req_stall stays high; configuration writes are taken.
// A stalled result holds the pipeline stage behind it and then the input.

module label_grouped_column_sum
   import lgcs_pkg::*;
#(
   parameter int MAX_LABELS  = DEF_MAX_LABELS,
   parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_cmd,
   input  logic [LABEL_W-1:0]     req_label,
   input  logic [COLUMN_W-1:0]    req_column,
   input  value_type              req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [STATUS_W-1:0]    rsp_status,
   output sum_type                rsp_sum,
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]       csr_data
);

`include "label_grouped_column_sum_assert.svh"

   localparam int DEPTH  = MAX_LABELS * MAX_COLUMNS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [CSR_W-1:0]    num_labels_ff, num_labels_in;
   logic [CSR_W-1:0]    num_columns_ff, num_columns_in;
   logic                clr_active_ff, clr_active_in;
   logic [ADDR_W-1:0]   clr_addr_ff, clr_addr_in;
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_cmd_ff, s1_cmd_in;
   logic [STATUS_W-1:0] s1_status_ff, s1_status_in;
   logic [ADDR_W-1:0]   s1_addr_ff, s1_addr_in;
   value_type           s1_value_ff, s1_value_in;
   logic                s1_fwd_ff, s1_fwd_in;
   sum_type             s1_fwd_data_ff, s1_fwd_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   sum_type             rsp_sum_ff, rsp_sum_in;

   logic                out_free;
   logic                s1_adv;
   logic                s1_write;
   logic                req_accept;
   logic                label_bad;
   logic                column_bad;
   logic [STATUS_W-1:0] req_status;
   logic [ADDR_W-1:0]   req_addr;
   sum_type             ram_rd_data;
   sum_type             s1_old;
   sum_type             s1_new;
   sum_type             s1_result;
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   sum_type             ram_wr_data;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_adv     = s1_valid_ff && out_free;
   assign req_stall  = clr_active_ff || (s1_valid_ff && !out_free);
   assign req_accept = req_valid && !req_stall;

   assign label_bad  = (CSR_W'(req_label) >= num_labels_ff) ||
                       (32'(req_label) >= MAX_LABELS);
   assign column_bad = (CSR_W'(req_column) >= num_columns_ff) ||
                       (32'(req_column) >= MAX_COLUMNS);
   assign req_status = label_bad ? STATUS_BAD_LABEL :
                       column_bad ? STATUS_BAD_COLUMN : STATUS_OK;
   assign req_addr   = ADDR_W'(32'(req_label) * MAX_COLUMNS + 32'(req_column));

   assign s1_old    = s1_fwd_ff ? s1_fwd_data_ff : ram_rd_data;
   assign s1_new    = (s1_cmd_ff == CMD_ADD) ? sat_add(s1_old, s1_value_ff) : '0;
   assign s1_result = (s1_status_ff != STATUS_OK) ? '0 :
                      (s1_cmd_ff == CMD_ADD) ? s1_new : s1_old;
   assign s1_write  = s1_adv && (s1_status_ff == STATUS_OK);

   assign ram_wr_en   = clr_active_ff || s1_write;
   assign ram_wr_addr = clr_active_ff ? clr_addr_ff : s1_addr_ff;
   assign ram_wr_data = clr_active_ff ? '0 : s1_new;

   lgcs_ram #(
      .WIDTH (SUM_W),
      .DEPTH (DEPTH),
      .ADDR_W(ADDR_W)
   ) u_sums (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (req_accept),
      .rd_addr(req_addr),
      .rd_data(ram_rd_data)
   );

   always_comb begin
      num_labels_in  = num_labels_ff;
      num_columns_in = num_columns_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_NUM_LABELS:  num_labels_in = csr_data;
            CSR_NUM_COLUMNS: num_columns_in = csr_data;
            default: ;
         endcase
      end

      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clr_active_in = 1'b0;
         end
      end

      s1_valid_in    = s1_valid_ff;
      s1_cmd_in      = s1_cmd_ff;
      s1_status_in   = s1_status_ff;
      s1_addr_in     = s1_addr_ff;
      s1_value_in    = s1_value_ff;
      s1_fwd_in      = s1_fwd_ff;
      s1_fwd_data_in = s1_fwd_data_ff;
      if (req_accept) begin
         s1_valid_in    = 1'b1;
         s1_cmd_in      = req_cmd;
         s1_status_in   = req_status;
         s1_addr_in     = req_addr;
         s1_value_in    = req_value;
         s1_fwd_in      = s1_write && (s1_addr_ff == req_addr);
         s1_fwd_data_in = s1_new;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_sum_in    = rsp_sum_ff;
      if (s1_adv) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = s1_status_ff;
         rsp_sum_in    = s1_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_labels_ff  <= NUM_LABELS_RESET;
         num_columns_ff <= NUM_COLUMNS_RESET;
         clr_active_ff  <= 1'b1;
         clr_addr_ff    <= '0;
         s1_valid_ff    <= 1'b0;
         s1_fwd_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         num_labels_ff  <= num_labels_in;
         num_columns_ff <= num_columns_in;
         clr_active_ff  <= clr_active_in;
         clr_addr_ff    <= clr_addr_in;
         s1_valid_ff    <= s1_valid_in;
         s1_fwd_ff      <= s1_fwd_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      s1_cmd_ff      <= s1_cmd_in;
      s1_status_ff   <= s1_status_in;
      s1_addr_ff     <= s1_addr_in;
      s1_value_ff    <= s1_value_in;
      s1_fwd_data_ff <= s1_fwd_data_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_sum_ff     <= rsp_sum_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_sum    = rsp_sum_ff;

   `LGCS_ASSERT_SAME(a_clear_pipe_empty, clr_active_ff, !s1_valid_ff && !rsp_valid_ff,
      "Pipeline holds an item while the sum RAM is being cleared.")
   `LGCS_ASSERT_NEXT(a_adv_makes_rsp, s1_adv, rsp_valid_ff,
      "An item left the pipeline stage without reaching the result register.")
   `LGCS_ASSERT_NEXT(a_stall_holds_s1, s1_valid_ff && !out_free,
      s1_valid_ff && $stable(s1_addr_ff) && $stable(s1_status_ff),
      "A held pipeline stage changed while the result was stalled.")
   `LGCS_ASSERT_SAME(a_error_sum_zero, rsp_valid && (rsp_status != STATUS_OK), rsp_sum == '0,
      "An error result carries a nonzero sum.")

endmodule
